// File: rtl/core/bfcfs_pkg.sv
// shared types, codes and helpers for the backface cull and flat shade block
package bfcfs_pkg;

  localparam int IN_W  = 176;
  localparam int OUT_W = 136;

  // configuration register indexes
  localparam logic [2:0] CFG_CAMERA_X   = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y   = 3'd1;
  localparam logic [2:0] CFG_CAMERA_Z   = 3'd2;
  localparam logic [2:0] CFG_REFL_RED   = 3'd3;
  localparam logic [2:0] CFG_REFL_GREEN = 3'd4;
  localparam logic [2:0] CFG_REFL_BLUE  = 3'd5;
  localparam logic [2:0] CFG_LIGHT_CNT  = 3'd6;

  localparam logic [15:0] REFL_ONE = 16'd16384;
  localparam logic [7:0]  CH_MAX   = 8'd255;

  // last step index of each multi-cycle phase
  localparam logic [5:0] NORM_LAST  = 6'd5;
  localparam logic [5:0] CULL_LAST  = 6'd2;
  localparam logic [5:0] SQ_LAST    = 6'd2;
  localparam logic [5:0] SQRT_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST   = 6'd46;
  localparam logic [5:0] LIGHT_LAST = 6'd12;
  localparam logic [1:0] COMP_LAST  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CAPTURE, OP_NORM, OP_CULL, OP_MAG, OP_RED, OP_SQ,
    OP_SQRT, OP_DIV, OP_STORE, OP_LIGHT, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] idx;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic red_more;
    logic no_lights;
    logic last_light;
    logic out_free;
  } stat_t;

  // Q.44 channel sum to 0..255
  function automatic logic [7:0] sat_ch(input logic signed [61:0] s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s[61:44] > 18'(CH_MAX)) begin
      r = CH_MAX;
    end else begin
      r = s[51:44];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/bfcfs_ctrl.sv
// sequencer that steps the datapath through load and shade work
module bfcfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfcfs_pkg::stat_t  stat,
  output bfcfs_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_START = 12'b0000_0000_0010,
    S_NORM  = 12'b0000_0000_0100,
    S_CULL  = 12'b0000_0000_1000,
    S_MAG   = 12'b0000_0001_0000,
    S_RED   = 12'b0000_0010_0000,
    S_SQ    = 12'b0000_0100_0000,
    S_SQRT  = 12'b0000_1000_0000,
    S_DIV   = 12'b0001_0000_0000,
    S_STORE = 12'b0010_0000_0000,
    S_LIGHT = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [5:0] idx, idx_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx + 6'd1;
    sel_next   = sel;
    in_ready   = 1'b0;
    cmd.op     = bfcfs_pkg::OP_IDLE;
    cmd.idx    = idx;
    cmd.sel    = sel;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        idx_next = '0;
        sel_next = '0;
        if (in_valid) begin
          cmd.op     = bfcfs_pkg::OP_CAPTURE;
          state_next = S_START;
        end
      end
      S_START: begin
        idx_next   = '0;
        state_next = stat.is_load ? S_SQ : S_NORM;
      end
      S_NORM: begin
        cmd.op = bfcfs_pkg::OP_NORM;
        if (idx == bfcfs_pkg::NORM_LAST) begin
          idx_next   = '0;
          state_next = S_CULL;
        end
      end
      S_CULL: begin
        cmd.op = bfcfs_pkg::OP_CULL;
        if (idx == bfcfs_pkg::CULL_LAST) begin
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op     = bfcfs_pkg::OP_MAG;
        state_next = S_RED;
      end
      S_RED: begin
        idx_next = '0;
        if (stat.red_more) begin
          cmd.op = bfcfs_pkg::OP_RED;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = bfcfs_pkg::OP_SQ;
        if (idx == bfcfs_pkg::SQ_LAST) begin
          idx_next   = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = bfcfs_pkg::OP_SQRT;
        if (idx == bfcfs_pkg::SQRT_LAST) begin
          idx_next   = '0;
          sel_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = bfcfs_pkg::OP_DIV;
        if (idx == bfcfs_pkg::DIV_LAST) begin
          idx_next = '0;
          sel_next = sel + 2'd1;
          if (sel == bfcfs_pkg::COMP_LAST) begin
            if (stat.is_load) begin
              state_next = S_STORE;
            end else if (stat.no_lights) begin
              state_next = S_DONE;
            end else begin
              state_next = S_LIGHT;
            end
          end
        end
      end
      S_STORE: begin
        cmd.op     = bfcfs_pkg::OP_STORE;
        state_next = S_IDLE;
      end
      S_LIGHT: begin
        cmd.op = bfcfs_pkg::OP_LIGHT;
        if (idx == bfcfs_pkg::LIGHT_LAST) begin
          idx_next = '0;
          if (stat.last_light) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = bfcfs_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a word is only taken with no other work in flight
  assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid) |=> (state == S_START))
    else $error("capture did not start a job");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && idx == bfcfs_pkg::DIV_LAST && sel == bfcfs_pkg::COMP_LAST &&
     stat.is_load) |=> (state == S_STORE))
    else $error("light load skipped the table write");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && stat.out_free) |=> (state == S_IDLE))
    else $error("result hand-off did not return to idle");

endmodule

// File: rtl/core/bfcfs_dp.sv
// datapath: registers, config, light tables, multiplier steps, sqrt and divide
module bfcfs_dp #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfcfs_pkg::cmd_t               cmd,
  output bfcfs_pkg::stat_t              stat,
  input  logic [bfcfs_pkg::IN_W-1:0]    in_data,
  input  logic                          operation,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfcfs_pkg::OUT_W-1:0]   out_data
);

  localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CW = $clog2(MAX_LIGHTS + 1);

  // input fields
  logic        [2:0]  light_slot;
  logic        [23:0] light_rgb;
  logic signed [15:0] p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
  assign light_slot = in_data[2:0];
  assign light_rgb  = in_data[26:3];
  assign p0_x = in_data[42:27];
  assign p0_y = in_data[58:43];
  assign p0_z = in_data[74:59];
  assign p1_x = in_data[90:75];
  assign p1_y = in_data[106:91];
  assign p1_z = in_data[122:107];
  assign p2_x = in_data[138:123];
  assign p2_y = in_data[154:139];
  assign p2_z = in_data[170:155];

  // config
  logic signed [15:0] cam [3];
  logic        [15:0] refl [3];
  logic        [3:0]  light_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam[0]      <= '0;
      cam[1]      <= '0;
      cam[2]      <= '0;
      refl[0]     <= bfcfs_pkg::REFL_ONE;
      refl[1]     <= bfcfs_pkg::REFL_ONE;
      refl[2]     <= bfcfs_pkg::REFL_ONE;
      light_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfcfs_pkg::CFG_CAMERA_X:   cam[0]      <= cfg_data;
        bfcfs_pkg::CFG_CAMERA_Y:   cam[1]      <= cfg_data;
        bfcfs_pkg::CFG_CAMERA_Z:   cam[2]      <= cfg_data;
        bfcfs_pkg::CFG_REFL_RED:   refl[0]     <= cfg_data;
        bfcfs_pkg::CFG_REFL_GREEN: refl[1]     <= cfg_data;
        bfcfs_pkg::CFG_REFL_BLUE:  refl[2]     <= cfg_data;
        bfcfs_pkg::CFG_LIGHT_CNT:  light_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic                is_load;
  logic        [2:0]   slot;
  logic        [23:0]  rgb;
  logic signed [15:0]  v0 [3];
  logic signed [15:0]  v1 [3];
  logic signed [15:0]  v2 [3];
  logic signed [33:0]  t;
  logic signed [34:0]  n [3];
  logic signed [53:0]  cd;
  logic        [34:0]  mg [3];
  logic                sg [3];
  logic        [31:0]  ss;
  logic        [61:0]  srem;
  logic        [62:0]  root;
  logic        [31:0]  drem;
  logic        [46:0]  quo;
  logic signed [15:0]  u [3];
  logic        [CW-1:0] l;
  logic        [23:0]  rd_col;
  logic        [47:0]  rd_dir;
  logic signed [33:0]  cs;
  logic        [23:0]  cr;
  logic signed [58:0]  pp;
  logic signed [61:0]  acc [3];

  logic [23:0] col_tab [MAX_LIGHTS];
  logic [47:0] dir_tab [MAX_LIGHTS];

  // edges
  logic signed [16:0] a [3];
  logic signed [16:0] b [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = 17'(v0[i]) - 17'(v1[i]);
      b[i] = 17'(v0[i]) - 17'(v2[i]);
    end
  end

  // cross product operands
  logic [1:0]         nci, j1, j2;
  logic signed [16:0] mx, my;
  logic signed [33:0] nprod;
  assign nci = cmd.idx[2:1];
  always_comb begin
    case (nci)
      2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
      2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
      default: begin j1 = 2'd0; j2 = 2'd1; end
    endcase
    mx = cmd.idx[0] ? b[j2] : b[j1];
    my = cmd.idx[0] ? a[j1] : a[j2];
  end
  assign nprod = mx * my;

  // facing test term
  logic [1:0]         ci;
  logic signed [16:0] dcam;
  logic signed [51:0] cprod;
  assign ci    = cmd.idx[1:0];
  assign dcam  = 17'(v0[ci]) - 17'(cam[ci]);
  assign cprod = n[ci] * dcam;

  // load magnitudes from p0
  logic signed [16:0] p0e [3];
  logic signed [16:0] p0m [3];
  always_comb begin
    p0e[0] = 17'(p0_x);
    p0e[1] = 17'(p0_y);
    p0e[2] = 17'(p0_z);
    for (int i = 0; i < 3; i++) begin
      p0m[i] = p0e[i][16] ? -p0e[i] : p0e[i];
    end
  end

  logic [33:0] sq;
  assign sq = mg[ci][16:0] * mg[ci][16:0];

  // square root step, two bits of the radicand a cycle
  logic [61:0] nc;
  logic [62:0] rc, bb, trial;
  always_comb begin
    nc    = (cmd.idx == '0) ? {ss, 30'd0} : srem;
    rc    = (cmd.idx == '0) ? '0 : root;
    bb    = 63'd1 << (7'd62 - {cmd.idx[4:0], 1'b0});
    trial = rc + bb;
  end

  // restoring divide step, one quotient bit a cycle
  logic [46:0] dvd;
  logic [32:0] rsh;
  logic        ge;
  logic [46:0] qn;
  logic [15:0] usat;
  always_comb begin
    dvd  = {mg[cmd.sel][16:0], 30'd0};
    rsh  = {((cmd.idx == '0) ? 32'd0 : drem), dvd[6'd46 - cmd.idx]};
    ge   = rsh >= 33'(root[31:0]);
    qn   = {((cmd.idx == '0) ? 46'd0 : quo[45:0]), ge};
    usat = (qn > 47'd32767) ? 16'd32767 : qn[15:0];
  end

  // light loop operands
  logic [3:0]         lj;
  logic signed [15:0] dcomp, ucomp;
  logic signed [31:0] dprod;
  logic [CW-1:0]      cnt;
  assign lj = cmd.idx[3:0];
  always_comb begin
    case (lj)
      4'd1:    begin dcomp = rd_dir[15:0];  ucomp = u[0]; end
      4'd2:    begin dcomp = rd_dir[31:16]; ucomp = u[1]; end
      default: begin dcomp = rd_dir[47:32]; ucomp = u[2]; end
    endcase
  end
  assign dprod = dcomp * ucomp;
  assign cnt   = (32'(light_count) > MAX_LIGHTS) ? CW'(MAX_LIGHTS) : CW'(light_count);

  logic signed [58:0] ppn;
  assign ppn = $signed({1'b0, cr}) * cs;

  always_ff @(posedge clk) begin
    case (cmd.op)
      bfcfs_pkg::OP_CAPTURE: begin
        is_load <= operation;
        slot    <= light_slot;
        rgb     <= light_rgb;
        v0[0] <= p0_x; v0[1] <= p0_y; v0[2] <= p0_z;
        v1[0] <= p1_x; v1[1] <= p1_y; v1[2] <= p1_z;
        v2[0] <= p2_x; v2[1] <= p2_y; v2[2] <= p2_z;
        for (int i = 0; i < 3; i++) begin
          mg[i]  <= 35'(p0m[i]);
          sg[i]  <= p0e[i][16];
          acc[i] <= '0;
        end
        l <= '0;
      end
      bfcfs_pkg::OP_NORM: begin
        if (!cmd.idx[0]) begin
          t <= nprod;
        end else begin
          n[nci] <= 35'(t) - 35'(nprod);
        end
      end
      bfcfs_pkg::OP_CULL: begin
        cd <= ((cmd.idx == '0) ? 54'sd0 : cd) + 54'(cprod);
      end
      bfcfs_pkg::OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mg[i] <= n[i][34] ? 35'(-n[i]) : 35'(n[i]);
          sg[i] <= n[i][34];
        end
      end
      bfcfs_pkg::OP_RED: begin
        for (int i = 0; i < 3; i++) begin
          mg[i] <= mg[i] >> 1;
        end
      end
      bfcfs_pkg::OP_SQ: begin
        ss <= ((cmd.idx == '0) ? 32'd0 : ss) + sq[31:0];
      end
      bfcfs_pkg::OP_SQRT: begin
        if ({1'b0, nc} >= trial) begin
          srem <= nc - trial[61:0];
          root <= (rc >> 1) + bb;
        end else begin
          srem <= nc;
          root <= rc >> 1;
        end
      end
      bfcfs_pkg::OP_DIV: begin
        drem <= ge ? 32'(rsh - 33'(root[31:0])) : rsh[31:0];
        quo  <= qn;
        if (cmd.idx == bfcfs_pkg::DIV_LAST) begin
          if (ss == '0) begin
            u[cmd.sel] <= '0;
          end else begin
            u[cmd.sel] <= sg[cmd.sel] ? -$signed(usat) : $signed(usat);
          end
        end
      end
      bfcfs_pkg::OP_LIGHT: begin
        case (lj)
          4'd0: begin
            rd_col <= col_tab[l[AW-1:0]];
            rd_dir <= dir_tab[l[AW-1:0]];
          end
          4'd1:  cs <= 34'(dprod);
          4'd2,
          4'd3:  cs <= cs + 34'(dprod);
          4'd4:  cr <= rd_col[23:16] * refl[0];
          4'd7:  cr <= rd_col[15:8] * refl[1];
          4'd10: cr <= rd_col[7:0] * refl[2];
          4'd5,
          4'd8,
          4'd11: pp <= ppn;
          4'd6:  acc[0] <= acc[0] + 62'(pp);
          4'd9:  acc[1] <= acc[1] + 62'(pp);
          4'd12: begin
            acc[2] <= acc[2] + 62'(pp);
            l      <= l + 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // light tables
  always_ff @(posedge clk) begin
    if (cmd.op == bfcfs_pkg::OP_STORE && 32'(slot) < MAX_LIGHTS) begin
      col_tab[AW'(slot)] <= rgb;
      dir_tab[AW'(slot)] <= {u[2], u[1], u[0]};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == bfcfs_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bfcfs_pkg::OP_OUT) begin
      out_data <= {6'd0,
                   bfcfs_pkg::sat_ch(acc[2]), bfcfs_pkg::sat_ch(acc[1]),
                   bfcfs_pkg::sat_ch(acc[0]),
                   n[2], n[1], n[0], cd[53]};
    end
  end

  assign stat.is_load    = is_load;
  assign stat.red_more   = |(mg[0][34:15] | mg[1][34:15] | mg[2][34:15]);
  assign stat.no_lights  = (cnt == '0);
  assign stat.last_light = ((CW+1)'(l) + 1'b1) == (CW+1)'(cnt);
  assign stat.out_free   = !out_valid || out_ready;

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfcfs_pkg::OP_OUT) |-> (!out_valid || out_ready))
    else $error("result overwrote a word still waiting");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfcfs_pkg::OP_SQRT && cmd.idx == bfcfs_pkg::SQRT_LAST) |=>
    (root[62:32] == '0))
    else $error("square root out of range");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfcfs_pkg::OP_DIV && ss != '0) |=> (drem < root[31:0]))
    else $error("divide remainder not below divisor");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bfcfs_pkg::OP_LIGHT) |-> (l < cnt))
    else $error("light index past active count");

endmodule

// File: rtl/core/backface_cull_flat_shade_unit.sv
// top level: back-face cull and flat lambert shade of one triangle
//
// input stream s_axis: one word per item. tuser selects the item kind:
// 0 shades the triangle in tdata, 1 loads a light (colour and direction)
// into the table entry light_slot. a load gives no output word; a shade
// gives one output word on m_axis with the cull flag, the raw face normal
// and the three saturated colour channels.
// cfg: write-only register port (cfg_valid/cfg_ready, cfg_index, cfg_data),
// always ready; write only while no item is in progress.
// operation: one item at a time through the multipliers, square root and
// restoring divider. a load runs 3 squares, 32 root steps and 3 x 47 divide
// steps. a shade runs the normal cross product, the facing test, the normal
// range reduction and the same square, root and divide steps, then 13 steps
// for each active light on the multiply-accumulate path.
// the output word sits in a register: the next item is accepted while a
// result waits, and a later result waits in its last step until m_axis_tready.
// reset clears config to defaults and the handshake state; light table
// entries are undefined until loaded.
module backface_cull_flat_shade_unit #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // light_slot[2:0] light_rgb[26:3] p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z
  // (16 bits each from bit 27 up), zero pad [175:171]
  input  logic [175:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // culled[0] normal_x[35:1] normal_y[70:36] normal_z[105:71]
  // shade_red[113:106] shade_green[121:114] shade_blue[129:122], zero pad
  output logic [135:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  bfcfs_pkg::cmd_t  cmd;
  bfcfs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bfcfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfcfs_dp #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .operation (s_axis_tuser[0]),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
